>>> rtl/sidt_pkg.sv
// Shared types and constants for the signed integer to decimal text converter.
`default_nettype none

package sidt_pkg;

  // Magnitude width and the widened width used by the trial subtraction.
  localparam int unsigned MAG_W   = 32;
  localparam int unsigned TRIAL_W = MAG_W + 4;

  // Decade index (0 to 9) and digit bit index (0 to 3) widths.
  localparam int unsigned DEC_W = 4;
  localparam int unsigned BIT_W = 2;

  // Highest decade of a 32-bit magnitude.
  localparam logic [DEC_W-1:0] DEC_TOP = 4'd9;
  localparam logic [DEC_W-1:0] DEC_LOW = 4'd0;

  // ASCII codes.
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;

  // Result of one compare-subtract step.
  typedef struct packed {
    logic             ge;
    logic [MAG_W-1:0] rem;
  } sidt_step_t;

  // Powers of ten from 10^0 to 10^9.
  function automatic logic [TRIAL_W-1:0] pow10(input logic [DEC_W-1:0] k);
    logic [TRIAL_W-1:0] p;
    case (k)
      4'd0:    p = 36'd1;
      4'd1:    p = 36'd10;
      4'd2:    p = 36'd100;
      4'd3:    p = 36'd1000;
      4'd4:    p = 36'd10000;
      4'd5:    p = 36'd100000;
      4'd6:    p = 36'd1000000;
      4'd7:    p = 36'd10000000;
      4'd8:    p = 36'd100000000;
      4'd9:    p = 36'd1000000000;
      default: p = 36'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> rtl/signed_int_to_decimal_text.sv
// Top level of the signed 32-bit integer to decimal ASCII text converter.
`default_nettype none

// A value is taken when start is high and busy is low. A negative value shows
// '-' in the cycle after it is taken. The digits are then found most significant
// first by one shared compare-subtract unit, one digit bit per cycle, four digit
// bits per decade over ten decades, so busy stays high until the last decade is
// done, and no new value is taken before then. Each character is on the out_
// ports for exactly one cycle with out_valid high, leading zeros are skipped,
// and out_is_last marks the final digit. The receiver cannot stall the output.
module signed_int_to_decimal_text (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic signed [31:0] in_value,
  output logic             out_valid,
  output logic [7:0]       out_text_char,
  output logic             out_is_last
);
  import sidt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CONV = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [MAG_W-1:0]   mag_r, mag_nxt;
  logic [DEC_W-1:0]   dec_r, dec_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic [2:0]         digit_r, digit_nxt;
  logic               started_r, started_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         char_r, char_nxt;
  logic               last_r, last_nxt;
  logic               accept;
  logic [3:0]         digit_full;
  logic [MAG_W-1:0]   in_bits;
  sidt_step_t         step;

  sidt_cmpsub u_cmpsub (
    .mag     (mag_r),
    .dec_idx (dec_r),
    .bit_idx (bit_r),
    .step    (step)
  );

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign in_bits = in_value;
  assign digit_full = {digit_r, step.ge};

  // Sequencer: decade and bit counters walk the shared unit over the magnitude.
  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    dec_nxt       = dec_r;
    bit_nxt       = bit_r;
    digit_nxt     = digit_r;
    started_nxt   = started_r;
    out_valid_nxt = 1'b0;
    char_nxt      = char_r;
    last_nxt      = last_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt   = ST_CONV;
          mag_nxt     = in_bits[MAG_W-1] ? (32'd0 - in_bits) : in_bits;
          dec_nxt     = DEC_TOP;
          bit_nxt     = 2'd3;
          digit_nxt   = 3'd0;
          started_nxt = 1'b0;
          if (in_bits[MAG_W-1]) begin
            out_valid_nxt = 1'b1;
            char_nxt      = CHAR_MINUS;
            last_nxt      = 1'b0;
          end
        end
      end
      ST_CONV: begin
        mag_nxt   = step.rem;
        digit_nxt = digit_full[2:0];
        bit_nxt   = bit_r - 2'd1;
        if (bit_r == 2'd0) begin
          // A digit is complete: emit it unless it is a leading zero.
          digit_nxt = 3'd0;
          if (started_r || (digit_full != 4'd0) || (dec_r == DEC_LOW)) begin
            started_nxt   = 1'b1;
            out_valid_nxt = 1'b1;
            char_nxt      = CHAR_ZERO + {4'd0, digit_full};
            last_nxt      = (dec_r == DEC_LOW);
          end
          if (dec_r == DEC_LOW) begin
            state_nxt = ST_IDLE;
          end else begin
            dec_nxt = dec_r - 4'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    dec_r   <= dec_nxt;
    bit_r   <= bit_nxt;
    digit_r <= digit_nxt;
    char_r  <= char_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = char_r;
  assign out_is_last   = last_r;

  // Right after the end of a run, only the minus sign of a new value can appear.
  a_last_then_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_last |=> !out_valid || (out_text_char == CHAR_MINUS))
    else $error("digit emitted right after end of run");

  // The minus sign never ends a run.
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_text_char == CHAR_MINUS) |-> !out_is_last)
    else $error("minus sign marked as last character");

  // A taken transaction makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after transaction");

  // A run ends only as conversion finishes.
  a_last_ends_conv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_last |-> !busy)
    else $error("run ended while conversion still active");

endmodule

`default_nettype wire

>>> rtl/sidt_cmpsub.sv
// Shared compare-subtract unit: tests the magnitude against a weighted power of ten.
`default_nettype none

module sidt_cmpsub (
  input  wire logic [sidt_pkg::MAG_W-1:0] mag,
  input  wire logic [sidt_pkg::DEC_W-1:0] dec_idx,
  input  wire logic [sidt_pkg::BIT_W-1:0] bit_idx,
  output sidt_pkg::sidt_step_t            step
);
  import sidt_pkg::*;

  logic [TRIAL_W-1:0] trial;
  logic [TRIAL_W:0]   diff;

  // Weight the decade by 8, 4, 2 or 1 and subtract; no borrow means the bit is set.
  always_comb begin
    trial     = pow10(dec_idx) << bit_idx;
    diff      = {1'b0, {(TRIAL_W-MAG_W){1'b0}}, mag} - {1'b0, trial};
    step.ge   = ~diff[TRIAL_W];
    step.rem  = step.ge ? diff[MAG_W-1:0] : mag;
  end

endmodule

`default_nettype wire

>>> sim/decimal_text_checker.sv
// Checker that predicts and compares the decimal text produced for each accepted value.
`timescale 1ns / 100ps

module decimal_text_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] in_value,
  input  logic        out_valid,
  input  logic [7:0]  out_text_char,
  input  logic        out_is_last,
  output int          mismatch_count,
  output int          pending_chars
);
  import sidt_pkg::*;

  // One character of expected text and its end-of-run mark.
  typedef struct {
    logic [7:0] text_char;
    logic       is_last;
  } text_char_t;

  text_char_t expected_chars[$];

  assign pending_chars = expected_chars.size();

  // Appends the decimal text of one value, most significant character first.
  function automatic void predict_decimal_text(input logic [31:0] value);
    logic        negative;
    logic [31:0] magnitude;
    logic [3:0]  digits[10];
    int          num_digits;
    text_char_t  ch;
    negative   = value[31];
    magnitude  = negative ? (32'd0 - value) : value;
    num_digits = 0;
    do begin
      digits[num_digits] = 4'(magnitude % 32'd10);
      magnitude          = magnitude / 32'd10;
      num_digits++;
    end while (magnitude != 32'd0 && num_digits < 10);
    if (negative) begin
      ch.text_char = CHAR_MINUS;
      ch.is_last   = 1'b0;
      expected_chars.push_back(ch);
    end
    for (int k = num_digits - 1; k >= 0; k--) begin
      ch.text_char = CHAR_ZERO + 8'(digits[k]);
      ch.is_last   = (k == 0);
      expected_chars.push_back(ch);
    end
  endfunction

  // Compare each emitted character with the oldest expectation, then queue new text.
  always @(posedge clk) begin
    text_char_t want;
    if (!rst_n) begin
      mismatch_count <= 0;
    end else if (out_valid) begin
      if (expected_chars.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10)
          $display("%0t: unexpected character: text_char=%0d is_last=%0b",
                   $realtime, out_text_char, out_is_last);
      end else begin
        want = expected_chars.pop_front();
        if (out_text_char !== want.text_char || out_is_last !== want.is_last) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display({"%0t: mismatch: expected text_char=%0d is_last=%0b, ",
                      "got text_char=%0d is_last=%0b"},
                     $realtime, want.text_char, want.is_last, out_text_char, out_is_last);
        end
      end
    end
    // A transaction on the input channel.
    if (rst_n && start && !busy)
      predict_decimal_text(in_value);
  end

endmodule

>>> sim/tb_top.sv
// Testbench top for the signed integer to decimal text converter: stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic [7:0]         out_text_char;
  logic               out_is_last;
  int                 mismatch_count;
  int                 pending_chars;

  signed_int_to_decimal_text uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_text_char (out_text_char),
    .out_is_last   (out_is_last)
  );

  decimal_text_checker text_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_text_char  (out_text_char),
    .out_is_last    (out_is_last),
    .mismatch_count (mismatch_count),
    .pending_chars  (pending_chars)
  );

  // 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Safety net in case the block stops responding.
  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Offers one value until it is taken, then idles if gap or wait_idle asks for it. With wait_idle
  // set, the gap is counted only once the block has finished the current value.
  task automatic send_value(input logic [31:0] value, input int gap, input bit wait_idle);
    @(negedge clk);
    start    <= 1'b1;
    in_value <= value;
    while (busy) @(negedge clk);
    @(posedge clk);
    if (gap > 0 || wait_idle) begin
      @(negedge clk);
      start    <= 1'b0;
      in_value <= $urandom;
      if (wait_idle)
        while (busy) @(negedge clk);
      repeat ((gap > 0) ? gap - 1 : 0) begin
        @(negedge clk);
        in_value <= $urandom;
      end
    end
  endtask

  // Holds off new values until every expected character has come out.
  task automatic drain_text();
    @(negedge clk);
    start <= 1'b0;
    while (pending_chars != 0 || busy) @(negedge clk);
  endtask

  // Random value: mostly a random digit count and sign, else raw bits or an extreme.
  function automatic logic [31:0] random_value();
    int unsigned num_digits;
    longint      limit;
    logic [31:0] magnitude;
    case ($urandom_range(9, 0))
      0, 1: return $urandom;
      2:    return ($urandom_range(1, 0) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: begin
        num_digits = $urandom_range(10, 1);
        limit      = 1;
        repeat (num_digits) limit = limit * 10;
        limit      = limit - 1;
        if (limit > 64'd2147483647) limit = 64'd2147483647;
        magnitude  = $urandom_range(32'(limit), 0);
        return ($urandom_range(1, 0) != 0) ? (32'd0 - magnitude) : magnitude;
      end
    endcase
  endfunction

  logic [31:0] directed_values[] = '{
    32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100, -32'sd5, 32'd7,
    32'd2147483647, 32'h8000_0000, -32'sd2147483647, 32'd1000000000, 32'd999999999,
    -32'sd999999999, -32'sd1000000000, 32'd1234567890, -32'sd1234567890,
    32'h5555_5555, 32'hAAAA_AAAA, 32'd1000000001, -32'sd100
  };

  initial begin
    int  gap;
    int  wait_cycles;
    bit  no_idle;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_value = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: extremes, zero, single digits, decade boundaries.
    foreach (directed_values[i]) begin
      send_value(directed_values[i], (i % 3 == 0) ? 0 : $urandom_range(12, 0), i % 5 == 4);
      if (i == 11) drain_text();
    end
    drain_text();

    // Random part, with bursts that idle only when the text is drained.
    no_idle = 1'b0;
    for (int i = 0; i < 300; i++) begin
      if (i % 25 == 0) no_idle = ($urandom_range(2, 0) == 0);
      gap = no_idle ? 0 : $urandom_range(12, 0);
      send_value(random_value(), gap, !no_idle && $urandom_range(7, 0) == 0);
      if ($urandom_range(39, 0) == 0) drain_text();
    end

    // Let the last text come out, then a short tail.
    @(negedge clk);
    start       <= 1'b0;
    wait_cycles = 0;
    while ((pending_chars != 0 || busy) && wait_cycles < 2000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (60) @(negedge clk);

    if (mismatch_count == 0 && pending_chars == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
